>>> design/pbpa_pkg.sv
// Shared types and codes of the paged block pool allocator.
`timescale 1ns / 1ps

package pbpa_pkg;

   // Request kinds carried on tuser
   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   // Result status codes
   localparam logic [1:0] STATUS_POOL      = 2'd0;
   localparam logic [1:0] STATUS_BACKING   = 2'd1;
   localparam logic [1:0] STATUS_EXHAUSTED = 2'd2;
   localparam logic [1:0] STATUS_NULL      = 2'd3;

   // Register indexes (byte address / 4)
   localparam logic [1:0] REG_BLOCK_BYTES     = 2'd0;
   localparam logic [1:0] REG_ALIGN_LOG2      = 2'd1;
   localparam logic [1:0] REG_BLOCKS_PER_PAGE = 2'd2;
   localparam logic [1:0] REG_BASE_ADDRESS    = 2'd3;

   // Field widths
   localparam int BLOCK_W     = 13;
   localparam int BPP_W       = 7;
   localparam int PAGE_BYTES_W = BLOCK_W + BPP_W;
   localparam int TOTAL_W     = 22;
   localparam int PIDX_W      = 3;

   localparam logic [BLOCK_W-1:0] BLOCK_MAX = 13'd4096;

   // Effective (clamped) pool geometry
   typedef struct packed {
      logic [BLOCK_W-1:0]      block_bytes;
      logic [BPP_W-1:0]        blocks_per_page;
      logic [31:0]             base_address;
      logic [PAGE_BYTES_W-1:0] page_bytes;
   } cfg_type;

endpackage

>>> design/pbpa_stack.sv
// Free stack memory: one write port, one read port with registered data.
`timescale 1ns / 1ps

module pbpa_stack #(
   parameter int DEPTH = 512,
   parameter int WIDTH = 35
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Synchronous write, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/pbpa_blkdiv.sv
// Restoring remainder unit: offset modulo block size, one quotient bit per cycle.
`timescale 1ns / 1ps

module pbpa_blkdiv #(
   parameter int STEPS = 6
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [pbpa_pkg::PAGE_BYTES_W-1:0]  dividend,
   input  logic [pbpa_pkg::BLOCK_W-1:0]       divisor,
   output logic                               done,
   output logic [pbpa_pkg::PAGE_BYTES_W-1:0]  remainder
);

   localparam int DW   = pbpa_pkg::PAGE_BYTES_W;
   localparam int CNTW = $clog2(STEPS + 1);

   logic [DW-1:0]   rem_ff, rem_in;
   logic [DW-1:0]   dvs_ff, dvs_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic            busy_ff, busy_in;
   logic            done_ff, done_in;

   // One compare and subtract against the shifted divisor per cycle
   always_comb begin
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = dividend;
         dvs_in  = DW'(divisor) << (STEPS - 1);
         cnt_in  = CNTW'(STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_ff >= dvs_ff) begin
            rem_in = rem_ff - dvs_ff;
         end
         dvs_in = dvs_ff >> 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNTW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

>>> design/pbpa_csr.sv
// Register file on the APB-style port, with clamping of the pool geometry.
`timescale 1ns / 1ps

module pbpa_csr #(
   parameter int MAX_PAGE_BLOCKS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [3:0]            paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready,
   output pbpa_pkg::cfg_type     cfg,
   output logic                  restart
);

   localparam int BW = pbpa_pkg::BLOCK_W;
   localparam int PW = pbpa_pkg::BPP_W;
   localparam logic [PW-1:0] BPP_CAP =
      (MAX_PAGE_BLOCKS > 127) ? PW'(127) : PW'(MAX_PAGE_BLOCKS);

   logic [BW-1:0] block_bytes_ff;
   logic [3:0]    align_log2_ff;
   logic [PW-1:0] bpp_ff;
   logic [31:0]   base_ff;
   logic [pbpa_pkg::PAGE_BYTES_W-1:0] page_bytes_ff;

   logic [BW-1:0] eff_block;
   logic [PW-1:0] eff_bpp;
   logic          wr_strobe;
   logic [1:0]    reg_idx;

   assign wr_strobe = psel & penable & pwrite;
   assign reg_idx   = paddr[3:2];
   assign pready    = 1'b1;
   assign restart   = wr_strobe;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         block_bytes_ff <= BW'(64);
         align_log2_ff  <= 4'd3;
         bpp_ff         <= PW'(32);
         base_ff        <= '0;
      end else if (wr_strobe) begin
         case (reg_idx)
            pbpa_pkg::REG_BLOCK_BYTES:     block_bytes_ff <= pwdata[BW-1:0];
            pbpa_pkg::REG_ALIGN_LOG2:      align_log2_ff  <= pwdata[3:0];
            pbpa_pkg::REG_BLOCKS_PER_PAGE: bpp_ff         <= pwdata[PW-1:0];
            pbpa_pkg::REG_BASE_ADDRESS:    base_ff        <= pwdata;
            default: ;
         endcase
      end
      // page size is registered from the clamped registers and follows them in the next cycle
      page_bytes_ff <= pbpa_pkg::PAGE_BYTES_W'(eff_block) *
                       pbpa_pkg::PAGE_BYTES_W'(eff_bpp);
   end

   // Clamp to the legal ranges
   always_comb begin
      if (block_bytes_ff == '0) begin
         eff_block = BW'(1);
      end else if (block_bytes_ff > pbpa_pkg::BLOCK_MAX) begin
         eff_block = pbpa_pkg::BLOCK_MAX;
      end else begin
         eff_block = block_bytes_ff;
      end
      if (bpp_ff == '0) begin
         eff_bpp = PW'(1);
      end else if (bpp_ff > BPP_CAP) begin
         eff_bpp = BPP_CAP;
      end else begin
         eff_bpp = bpp_ff;
      end
   end

   // Read-back of the raw registers
   always_comb begin
      case (reg_idx)
         pbpa_pkg::REG_BLOCK_BYTES:     prdata = 32'(block_bytes_ff);
         pbpa_pkg::REG_ALIGN_LOG2:      prdata = 32'(align_log2_ff);
         pbpa_pkg::REG_BLOCKS_PER_PAGE: prdata = 32'(bpp_ff);
         pbpa_pkg::REG_BASE_ADDRESS:    prdata = base_ff;
         default:                       prdata = '0;
      endcase
   end

   assign cfg.block_bytes     = eff_block;
   assign cfg.blocks_per_page = eff_bpp;
   assign cfg.base_address    = base_ff;
   assign cfg.page_bytes      = page_bytes_ff;

endmodule

>>> design/paged_block_pool_allocator_core.sv
// Paged block pool allocator. Requests are taken one at a time (req_tready is high
// only when the sequencer is idle); a result sits in an output register while the
// next request is taken. An allocate from a non-empty stack goes through the stack
// read, the align check and the byte total states S_TOT1 and S_TOT2 to the result.
// An allocate on an empty stack first builds a page, if fewer than MAX_PAGES are
// built, at one stack write per cycle; otherwise it reports exhaustion. A free
// scans one page per cycle (up to the pages in use), then on a hit runs the
// remainder unit to find the block base; a null free goes straight to the total.
// After reset and after every register write the pool restarts: page 0 is rebuilt,
// during which no request is taken. Writing any register restarts the pool.
`timescale 1ns / 1ps

module paged_block_pool_allocator_core #(
   parameter int MAX_PAGES       = 8,
   parameter int MAX_PAGE_BLOCKS = 64
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // request_bytes[31:0], request_align_log2[35:32],
                                    // free_address[67:36], zero[71:68]
   input  logic        req_tuser,   // cmd: 0 allocate, 1 free
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // granted_address[31:0], page_index[34:32],
                                    // total_allocated_bytes[56:35], zero[63:57]
   output logic [1:0]  rsp_tuser,   // status
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int DEPTH   = MAX_PAGES * MAX_PAGE_BLOCKS;
   localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW      = $clog2(DEPTH + 1);
   localparam int PW      = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
   localparam int GW      = $clog2(MAX_PAGES + 1);
   localparam int EW      = PW + 32;
   localparam int SW      = GW + pbpa_pkg::BPP_W;
   localparam int XW      = SW + CW;
   localparam int PRW     = CW + pbpa_pkg::BLOCK_W;
   localparam int TW      = pbpa_pkg::TOTAL_W;
   localparam int BPP_CAP = (MAX_PAGE_BLOCKS > 127) ? 127 : MAX_PAGE_BLOCKS;
   localparam int QSTEPS  = (BPP_CAP > 1) ? $clog2(BPP_CAP) : 1;

   // Sequencer states
   localparam logic [3:0] S_INIT      = 4'd0;
   localparam logic [3:0] S_ADD_SET   = 4'd1;
   localparam logic [3:0] S_ADD       = 4'd2;
   localparam logic [3:0] S_IDLE      = 4'd3;
   localparam logic [3:0] S_ALLOC_RD  = 4'd4;
   localparam logic [3:0] S_ALLOC_CHK = 4'd5;
   localparam logic [3:0] S_FREE_SCAN = 4'd6;
   localparam logic [3:0] S_DIV       = 4'd7;
   localparam logic [3:0] S_TOT1      = 4'd8;
   localparam logic [3:0] S_TOT2      = 4'd9;

   pbpa_pkg::cfg_type cfg;
   logic              restart;

   logic [3:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [GW-1:0] pages_ff, pages_in;
   logic [31:0]   next_start_ff, next_start_in;
   logic          add_ret_ff, add_ret_in;
   logic [31:0]   add_addr_ff, add_addr_in;
   logic [pbpa_pkg::BPP_W-1:0] add_left_ff, add_left_in;
   logic [GW-1:0] scan_idx_ff, scan_idx_in;
   logic [31:0]   scan_start_ff, scan_start_in;
   logic [31:0]   req_bytes_ff, req_bytes_in;
   logic [3:0]    req_align_ff, req_align_in;
   logic [31:0]   free_addr_ff, free_addr_in;
   logic [1:0]    res_status_ff, res_status_in;
   logic [31:0]   res_granted_ff, res_granted_in;
   logic [2:0]    res_page_ff, res_page_in;
   logic [CW-1:0] diff_ff, diff_in;
   logic          rsp_tvalid_ff, rsp_tvalid_in;
   logic [63:0]   rsp_tdata_ff, rsp_tdata_in;
   logic [1:0]    rsp_tuser_ff, rsp_tuser_in;

   // stack port
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [EW-1:0] wr_data;
   logic [AW-1:0] rd_addr;
   logic [EW-1:0] rd_data;
   logic [CW-1:0] count_m1;

   // remainder unit
   logic          div_start;
   logic          div_done;
   logic [pbpa_pkg::PAGE_BYTES_W-1:0] div_rem;

   // datapath terms
   logic [32:0]   amask;
   logic [32:0]   align_off;
   logic [32:0]   need;
   logic          fits;
   logic [31:0]   top_addr;
   logic [PW+2:0] top_page_ext;
   logic [PW+2:0] scan_page_ext;
   logic [31:0]   scan_off;
   logic          scan_hit;
   logic          stack_room;
   logic [SW-1:0] slots;
   logic [XW-1:0] slots_x;
   logic [XW-1:0] count_x;
   logic [XW-1:0] diff_x;
   logic [PRW-1:0] prod;
   logic [PRW+TW-1:0] prod_ext;
   logic [TW-1:0] total;
   logic          accept;

   pbpa_csr #(
      .MAX_PAGE_BLOCKS (MAX_PAGE_BLOCKS)
   ) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg),
      .restart (restart)
   );

   pbpa_stack #(
      .DEPTH (DEPTH),
      .WIDTH (EW)
   ) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   pbpa_blkdiv #(
      .STEPS (QSTEPS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (scan_off[pbpa_pkg::PAGE_BYTES_W-1:0]),
      .divisor   (cfg.block_bytes),
      .done      (div_done),
      .remainder (div_rem)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid & req_tready;

   // Stack addressing: push at count, top at count - 1
   assign count_m1   = count_ff - 1'b1;
   assign rd_addr    = count_m1[AW-1:0];
   assign wr_addr    = count_ff[AW-1:0];
   assign stack_room = (count_ff < CW'(DEPTH));

   // Alignment of the top block
   assign top_addr     = rd_data[31:0];
   assign top_page_ext = {3'b000, rd_data[EW-1:32]};
   assign amask        = (33'd1 << req_align_ff) - 33'd1;
   assign align_off    = (~{1'b0, top_addr} + 33'd1) & amask;
   assign need         = align_off + {1'b0, req_bytes_ff};
   assign fits         = (need <= 33'(cfg.block_bytes));

   // Page search for a free
   assign scan_off      = free_addr_ff - scan_start_ff;
   assign scan_hit      = (scan_off < 32'(cfg.page_bytes));
   assign scan_page_ext = {3'b000, scan_idx_ff[PW-1:0]};

   // Allocated byte total
   assign slots    = SW'(pages_ff) * SW'(cfg.blocks_per_page);
   assign slots_x  = XW'(slots);
   assign count_x  = XW'(count_ff);
   assign diff_x   = slots_x - count_x;
   assign prod     = PRW'(diff_ff) * PRW'(cfg.block_bytes);
   assign prod_ext = {{TW{1'b0}}, prod};
   assign total    = (|prod_ext[PRW+TW-1:TW]) ? {TW{1'b1}} : prod_ext[TW-1:0];

   // Sequencer
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      pages_in       = pages_ff;
      next_start_in  = next_start_ff;
      add_ret_in     = add_ret_ff;
      add_addr_in    = add_addr_ff;
      add_left_in    = add_left_ff;
      scan_idx_in    = scan_idx_ff;
      scan_start_in  = scan_start_ff;
      req_bytes_in   = req_bytes_ff;
      req_align_in   = req_align_ff;
      free_addr_in   = free_addr_ff;
      res_status_in  = res_status_ff;
      res_granted_in = res_granted_ff;
      res_page_in    = res_page_ff;
      diff_in        = diff_ff;
      rsp_tvalid_in  = rsp_tvalid_ff & ~rsp_tready;
      rsp_tdata_in   = rsp_tdata_ff;
      rsp_tuser_in   = rsp_tuser_ff;
      wr_en          = 1'b0;
      wr_data        = {pages_ff[PW-1:0], add_addr_ff};
      div_start      = 1'b0;

      case (state_ff)
         // empty pool, page 0 follows
         S_INIT: begin
            count_in      = '0;
            pages_in      = '0;
            next_start_in = cfg.base_address;
            add_ret_in    = 1'b0;
            state_in      = S_ADD_SET;
         end

         // last block of the new page goes in first
         S_ADD_SET: begin
            add_addr_in = next_start_ff + 32'(cfg.page_bytes) - 32'(cfg.block_bytes);
            add_left_in = cfg.blocks_per_page;
            state_in    = S_ADD;
         end

         S_ADD: begin
            wr_data     = {pages_ff[PW-1:0], add_addr_ff};
            wr_en       = stack_room;
            if (stack_room) begin
               count_in = count_ff + 1'b1;
            end
            add_addr_in = add_addr_ff - 32'(cfg.block_bytes);
            add_left_in = add_left_ff - 1'b1;
            if (add_left_ff == pbpa_pkg::BPP_W'(1)) begin
               pages_in      = pages_ff + 1'b1;
               next_start_in = next_start_ff + 32'(cfg.page_bytes);
               state_in      = add_ret_ff ? S_ALLOC_RD : S_IDLE;
            end
         end

         S_IDLE: begin
            if (accept) begin
               req_bytes_in   = req_tdata[31:0];
               req_align_in   = req_tdata[35:32];
               free_addr_in   = req_tdata[67:36];
               res_status_in  = pbpa_pkg::STATUS_POOL;
               res_granted_in = '0;
               res_page_in    = '0;
               if (req_tuser == pbpa_pkg::CMD_ALLOC) begin
                  if (count_ff != '0) begin
                     state_in = S_ALLOC_RD;
                  end else if (pages_ff < GW'(MAX_PAGES)) begin
                     add_ret_in = 1'b1;
                     state_in   = S_ADD_SET;
                  end else begin
                     res_status_in = pbpa_pkg::STATUS_EXHAUSTED;
                     state_in      = S_TOT1;
                  end
               end else if (req_tdata[67:36] == 32'd0) begin
                  res_status_in = pbpa_pkg::STATUS_NULL;
                  state_in      = S_TOT1;
               end else begin
                  scan_idx_in   = '0;
                  scan_start_in = cfg.base_address;
                  state_in      = S_FREE_SCAN;
               end
            end
         end

         // top entry is being read
         S_ALLOC_RD: begin
            state_in = S_ALLOC_CHK;
         end

         S_ALLOC_CHK: begin
            if (fits) begin
               count_in       = count_m1;
               res_granted_in = top_addr + align_off[31:0];
               res_page_in    = top_page_ext[2:0];
            end else begin
               res_status_in  = pbpa_pkg::STATUS_BACKING;
            end
            state_in = S_TOT1;
         end

         // one page per cycle, first match wins
         S_FREE_SCAN: begin
            if (scan_idx_ff == pages_ff) begin
               res_status_in = pbpa_pkg::STATUS_BACKING;
               state_in      = S_TOT1;
            end else if (scan_hit) begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end else begin
               scan_idx_in   = scan_idx_ff + 1'b1;
               scan_start_in = scan_start_ff + 32'(cfg.page_bytes);
            end
         end

         // block base is the address less its offset within the block
         S_DIV: begin
            if (div_done) begin
               wr_data     = {scan_idx_ff[PW-1:0], free_addr_ff - 32'(div_rem)};
               wr_en       = stack_room;
               if (stack_room) begin
                  count_in = count_ff + 1'b1;
               end
               res_page_in = scan_page_ext[2:0];
               state_in    = S_TOT1;
            end
         end

         S_TOT1: begin
            diff_in  = (count_x >= slots_x) ? '0 : diff_x[CW-1:0];
            state_in = S_TOT2;
         end

         // hand over once the output register is free
         S_TOT2: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {7'd0, total, res_page_ff, res_granted_ff};
               rsp_tuser_in  = res_status_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_INIT;
         end
      endcase

      if (restart) begin
         state_in = S_INIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_INIT;
         count_ff      <= '0;
         pages_ff      <= '0;
         add_ret_ff    <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         pages_ff      <= pages_in;
         add_ret_ff    <= add_ret_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      next_start_ff  <= next_start_in;
      add_addr_ff    <= add_addr_in;
      add_left_ff    <= add_left_in;
      scan_idx_ff    <= scan_idx_in;
      scan_start_ff  <= scan_start_in;
      req_bytes_ff   <= req_bytes_in;
      req_align_ff   <= req_align_in;
      free_addr_ff   <= free_addr_in;
      res_status_ff  <= res_status_in;
      res_granted_ff <= res_granted_in;
      res_page_ff    <= res_page_in;
      diff_ff        <= diff_in;
      rsp_tdata_ff   <= rsp_tdata_in;
      rsp_tuser_ff   <= rsp_tuser_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

>>> tb/pool_grant_checker.sv
// Scoreboard for the block pool allocator: watches the channels, predicts and compares results.
`timescale 1ns / 1ps

module pool_grant_checker #(
   parameter int MAX_PAGES       = 8,
   parameter int MAX_PAGE_BLOCKS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [71:0] req_tdata,   // request_bytes[31:0], request_align_log2[35:32],
                                    // free_address[67:36], zero[71:68]
   input  logic        req_tuser,   // cmd
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [63:0] rsp_tdata,   // granted_address[31:0], page_index[34:32],
                                    // total_allocated_bytes[56:35], zero[63:57]
   input  logic [1:0]  rsp_tuser,   // status
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          failures,
   output int          pending
);
   import pbpa_pkg::*;

   localparam int STACK_DEPTH = MAX_PAGES * MAX_PAGE_BLOCKS;

   typedef struct packed {
      logic [1:0]         status;
      logic [31:0]        granted;
      logic [PIDX_W-1:0]  page;
      logic [TOTAL_W-1:0] total;
   } pool_result_t;

   // register copies; the alignment register does not shape any result
   logic [BLOCK_W-1:0] cfg_block;
   logic [3:0]         cfg_align;
   logic [BPP_W-1:0]   cfg_bpp;
   logic [31:0]        cfg_base;

   // free stack of (page, block address) and per-page usage
   logic [PIDX_W-1:0]  stk_page [STACK_DEPTH];
   logic [31:0]        stk_addr [STACK_DEPTH];
   int unsigned        stk_count;
   int unsigned        pages;
   logic [6:0]         used_blocks [MAX_PAGES];

   pool_result_t       expected_results[$];
   int                 fail_count = 0;
   int                 queued = 0;

   assign failures = fail_count;
   assign pending  = queued;

   function automatic longint unsigned pool_block();
      if (cfg_block == '0) return 1;
      if (cfg_block > BLOCK_MAX) return BLOCK_MAX;
      return cfg_block;
   endfunction

   function automatic longint unsigned pool_bpp();
      if (cfg_bpp == '0) return 1;
      if (cfg_bpp > MAX_PAGE_BLOCKS) return MAX_PAGE_BLOCKS;
      return cfg_bpp;
   endfunction

   // page regions wrap modulo 2^32
   function automatic logic [31:0] page_origin(input int unsigned index);
      logic [63:0] sum;
      sum = {32'd0, cfg_base} + index * pool_block() * pool_bpp();
      return sum[31:0];
   endfunction

   // a push onto a full stack is dropped
   function automatic void push_entry(input logic [PIDX_W-1:0] page, input logic [31:0] addr);
      if (stk_count < STACK_DEPTH) begin
         stk_page[stk_count] = page;
         stk_addr[stk_count] = addr;
         stk_count++;
      end
   endfunction

   function automatic void grow_pool();
      longint unsigned blk, n;
      logic [31:0]     origin;
      blk    = pool_block();
      n      = pool_bpp();
      origin = page_origin(pages);
      // last block first, so the first block ends on top
      for (int i = 0; i < n; i++) push_entry(3'(pages), origin + 32'((n - 1 - i) * blk));
      if (pages < MAX_PAGES) used_blocks[pages] = '0;
      pages++;
   endfunction

   function automatic void rebuild_pool();
      stk_count = 0;
      pages     = 0;
      for (int i = 0; i < MAX_PAGES; i++) used_blocks[i] = '0;
      grow_pool();
   endfunction

   // saturates at zero after surplus frees, and at the field maximum
   function automatic logic [TOTAL_W-1:0] allocated_bytes();
      longint unsigned slots, t;
      slots = pages;
      slots = slots * pool_bpp();
      if (stk_count >= slots) return '0;
      t = (slots - stk_count) * pool_block();
      if (t > {TOTAL_W{1'b1}}) t = {TOTAL_W{1'b1}};
      return t[TOTAL_W-1:0];
   endfunction

   function automatic pool_result_t predict_result(input logic cmd, input logic [31:0] bytes,
                                                   input logic [3:0] ral,
                                                   input logic [31:0] faddr);
      pool_result_t      r;
      logic [63:0]       top_addr, amask, aligned;
      logic [PIDX_W-1:0] top_page;
      logic [31:0]       origin, offset, pbytes;
      longint unsigned   blk;
      bit                ok, found;
      r   = '0;
      blk = pool_block();
      if (cmd == CMD_ALLOC) begin
         ok = 1'b1;
         if (stk_count == 0) begin
            if (pages < MAX_PAGES) grow_pool();
            else ok = 1'b0;
         end
         if (!ok || stk_count == 0) begin
            r.status = STATUS_EXHAUSTED;
         end else begin
            top_addr = {32'd0, stk_addr[stk_count-1]};
            top_page = stk_page[stk_count-1];
            // alignment is done in 64 bits, the grant is cut to 32
            amask    = (64'd1 << ral) - 64'd1;
            aligned  = (top_addr + amask) & ~amask;
            if (aligned - top_addr + {32'd0, bytes} > blk) begin
               r.status = STATUS_BACKING;
            end else begin
               used_blocks[top_page] = used_blocks[top_page] + 7'd1;
               stk_count--;
               r.status  = STATUS_POOL;
               r.granted = aligned[31:0];
               r.page    = top_page;
            end
         end
      end else if (faddr == 32'd0) begin
         r.status = STATUS_NULL;
      end else begin
         pbytes   = 32'(blk * pool_bpp());
         found    = 1'b0;
         r.status = STATUS_BACKING;
         // first page holding the address wins
         for (int i = 0; i < MAX_PAGES && i < pages && !found; i++) begin
            origin = page_origin(i);
            offset = faddr - origin;
            if (offset < pbytes) begin
               used_blocks[i] = used_blocks[i] - 7'd1;
               push_entry(3'(i), origin + 32'((offset / blk) * blk));
               r.status = STATUS_POOL;
               r.page   = 3'(i);
               found    = 1'b1;
            end
         end
      end
      r.total = allocated_bytes();
      return r;
   endfunction

   function automatic void note_mismatch(input string what, input longint unsigned want,
                                         input longint unsigned got);
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      fail_count++;
   endfunction

   always @(posedge clock) begin
      pool_result_t want, got;
      if (reset) begin
         cfg_block = 13'd64;
         cfg_align = 4'd3;
         cfg_bpp   = 7'd32;
         cfg_base  = '0;
         rebuild_pool();
         expected_results.delete();
      end else begin
         // any register write restarts the pool
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               REG_BLOCK_BYTES:     cfg_block = csr_pwdata[BLOCK_W-1:0];
               REG_ALIGN_LOG2:      cfg_align = csr_pwdata[3:0];
               REG_BLOCKS_PER_PAGE: cfg_bpp   = csr_pwdata[BPP_W-1:0];
               REG_BASE_ADDRESS:    cfg_base  = csr_pwdata;
            endcase
            rebuild_pool();
         end
         // result side first, so a stray result never takes a fresh prediction
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tuser, rsp_tdata[31:0], rsp_tdata[34:32], rsp_tdata[56:35]};
            if (expected_results.size() == 0) begin
               $display("%0t: result with no request outstanding, expected none, actual %0h",
                        $time, got);
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               if (got.status !== want.status)   note_mismatch("status", want.status, got.status);
               if (got.granted !== want.granted) note_mismatch("granted_address", want.granted,
                                                               got.granted);
               if (got.page !== want.page)       note_mismatch("page_index", want.page, got.page);
               if (got.total !== want.total)     note_mismatch("total_allocated_bytes",
                                                               want.total, got.total);
            end
         end
         if (req_tvalid && req_tready)
            expected_results.push_back(predict_result(req_tuser, req_tdata[31:0],
                                                      req_tdata[35:32], req_tdata[67:36]));
      end
      queued = expected_results.size();
   end

endmodule

>>> tb/tb_paged_block_pool_allocator_core.sv
// Testbench top for the paged block pool allocator: stimulus, idling and the verdict.
`timescale 1ns / 1ps

module tb_paged_block_pool_allocator_core;
   import pbpa_pkg::*;

   localparam int POOL_PAGES       = 8;
   localparam int POOL_PAGE_BLOCKS = 64;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata   = '0;   // request_bytes[31:0], request_align_log2[35:32],
                                    // free_address[67:36], zero[71:68]
   logic        req_tuser   = CMD_ALLOC;   // cmd
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [63:0] rsp_tdata;          // granted_address[31:0], page_index[34:32],
                                    // total_allocated_bytes[56:35], zero[63:57]
   logic [1:0]  rsp_tuser;          // status
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [3:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int failures;
   int pending;
   int src_idle_pct   = 0;
   int sink_stall_pct = 0;

   // copy of the geometry registers, used to aim free addresses at the pool
   logic [BLOCK_W-1:0] reg_block = 13'd64;
   logic [BPP_W-1:0]   reg_bpp   = 7'd32;
   logic [31:0]        reg_base  = '0;

   paged_block_pool_allocator_core #(
      .MAX_PAGES       (POOL_PAGES),
      .MAX_PAGE_BLOCKS (POOL_PAGE_BLOCKS)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   pool_grant_checker #(
      .MAX_PAGES       (POOL_PAGES),
      .MAX_PAGE_BLOCKS (POOL_PAGE_BLOCKS)
   ) u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .failures    (failures),
      .pending     (pending)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // result side back-pressure
   always @(negedge clock) begin
      rsp_tready = ($urandom_range(99) >= sink_stall_pct);
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("Test completed with failures");
      $finish;
   end

   function automatic int unsigned span_block();
      if (reg_block == '0) return 1;
      if (reg_block > BLOCK_MAX) return BLOCK_MAX;
      return reg_block;
   endfunction

   function automatic int unsigned span_bpp();
      if (reg_bpp == '0) return 1;
      if (reg_bpp > POOL_PAGE_BLOCKS) return POOL_PAGE_BLOCKS;
      return reg_bpp;
   endfunction

   // setup then access cycle; entered and left at a falling edge
   task automatic csr_write(input logic [1:0] index, input logic [31:0] value);
      csr_psel    = 1'b1;
      csr_pwrite  = 1'b1;
      csr_penable = 1'b0;
      csr_paddr   = {index, 2'b00};
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      case (index)
         REG_BLOCK_BYTES:     reg_block = value[BLOCK_W-1:0];
         REG_ALIGN_LOG2:      ;
         REG_BLOCKS_PER_PAGE: reg_bpp = value[BPP_W-1:0];
         REG_BASE_ADDRESS:    reg_base = value;
      endcase
   endtask

   // one request, with an optional idle gap in front
   task automatic send_request(input logic cmd, input logic [31:0] bytes,
                               input logic [3:0] ral, input logic [31:0] faddr);
      if ($urandom_range(99) < src_idle_pct) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = cmd;
      req_tdata  = {4'b0000, faddr, ral, bytes};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid = 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   task automatic set_idling(input int src, input int sink);
      src_idle_pct   = src;
      sink_stall_pct = sink;
   endtask

   // new geometry with the extremes favoured; the base often wraps through zero
   task automatic random_config();
      logic [BLOCK_W-1:0] blk;
      logic [BPP_W-1:0]   bpp;
      logic [31:0]        base;
      case ($urandom_range(5))
         0:       blk = 13'd1;
         1:       blk = 13'd4096;
         2:       blk = 13'd0;
         3:       blk = 13'h1FFF;
         default: blk = 13'($urandom_range(1, 256));
      endcase
      case ($urandom_range(5))
         0:       bpp = 7'd1;
         1:       bpp = 7'd64;
         2:       bpp = 7'd0;
         3:       bpp = 7'h7F;
         default: bpp = 7'($urandom_range(2, 12));
      endcase
      csr_write(REG_BLOCK_BYTES, {19'd0, blk});
      csr_write(REG_BLOCKS_PER_PAGE, {25'd0, bpp});
      csr_write(REG_ALIGN_LOG2, $urandom_range(0, 15));
      case ($urandom_range(3))
         0:       base = $urandom();
         1:       base = 32'd0 - 32'(span_block() * span_bpp() * $urandom_range(1, 6));
         2:       base = '0;
         default: base = ($urandom() / span_block()) * span_block();
      endcase
      csr_write(REG_BASE_ADDRESS, base);
   endtask

   // mostly allocations that fit and frees aimed inside the pool
   task automatic random_phase(input int count);
      logic [31:0] bytes, addr;
      logic [3:0]  ral;
      int unsigned blk, span;
      for (int n = 0; n < count; n++) begin
         blk  = span_block();
         span = blk * span_bpp() * POOL_PAGES;
         if ($urandom_range(99) < 58) begin
            case ($urandom_range(9))
               8:       bytes = $urandom();
               9:       bytes = blk + $urandom_range(1, 16);
               default: bytes = $urandom_range(0, blk);
            endcase
            ral = ($urandom_range(3) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 3));
            send_request(CMD_ALLOC, bytes, ral, $urandom());
         end else begin
            case ($urandom_range(9))
               0:       addr = '0;
               1:       addr = $urandom();
               2:       addr = reg_base + $urandom_range(0, span / blk - 1) * blk;
               default: addr = reg_base + $urandom_range(0, span - 1);
            endcase
            send_request(CMD_FREE, $urandom(), 4'($urandom_range(0, 15)), addr);
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset geometry: 64-byte blocks, 32 per page, pool at zero
      send_request(CMD_ALLOC, 32'd64, 4'd0, 32'd0);
      send_request(CMD_ALLOC, 32'd0, 4'd15, 32'd0);
      send_request(CMD_ALLOC, 32'd65, 4'd0, 32'd0);
      send_request(CMD_ALLOC, 32'hFFFF_FFFF, 4'd0, 32'd0);
      send_request(CMD_ALLOC, 32'd1, 4'd6, 32'd0);
      send_request(CMD_FREE, 32'd0, 4'd0, 32'd0);
      send_request(CMD_FREE, 32'd0, 4'd0, 32'd69);
      send_request(CMD_FREE, 32'd0, 4'd0, 32'd64);
      // surplus free would drive the total below zero; it saturates at zero
      send_request(CMD_FREE, 32'd0, 4'd0, 32'd5);
      send_request(CMD_FREE, 32'd0, 4'd0, 32'hFFFF_FFFF);
      send_request(CMD_FREE, 32'd0, 4'd0, 32'd2048);
      drain();

      // clamped geometry: largest blocks, one per page, pool wrapping through zero
      csr_write(REG_BLOCK_BYTES, 32'h0000_1FFF);
      csr_write(REG_ALIGN_LOG2, 32'd0);
      csr_write(REG_BLOCKS_PER_PAGE, 32'd0);
      csr_write(REG_BASE_ADDRESS, 32'hFFFF_C000);
      for (int n = 0; n < 7; n++) send_request(CMD_ALLOC, 32'd4096, 4'd12, 32'd0);
      // new page stays although the request is too big
      send_request(CMD_ALLOC, 32'd4097, 4'd0, 32'd0);
      send_request(CMD_ALLOC, 32'd0, 4'd0, 32'd0);
      send_request(CMD_ALLOC, 32'd1, 4'd0, 32'd0);
      send_request(CMD_FREE, 32'd0, 4'd0, 32'h0000_0FFF);
      send_request(CMD_FREE, 32'd0, 4'd0, 32'hFFFF_FFFF);
      // alignment carries past 2^32
      send_request(CMD_ALLOC, 32'd0, 4'd15, 32'd0);
      send_request(CMD_FREE, 32'd0, 4'd0, 32'h0000_4000);
      drain();

      // random phases, each with its own geometry and idling mix
      for (int p = 0; p < 6; p++) begin
         case (p % 4)
            0:       set_idling(0, 0);
            1:       set_idling(55, 0);
            2:       set_idling(0, 55);
            default: set_idling(25, 25);
         endcase
         random_config();
         random_phase(75);
         drain();
      end

      // repeated frees of one-byte blocks until the stack overflows
      set_idling(25, 25);
      csr_write(REG_BLOCK_BYTES, 32'd1);
      csr_write(REG_BLOCKS_PER_PAGE, 32'd64);
      csr_write(REG_BASE_ADDRESS, $urandom());
      for (int n = 0; n < 470; n++)
         send_request(CMD_FREE, $urandom(), 4'($urandom_range(0, 15)),
                      reg_base + $urandom_range(0, 63));
      for (int n = 0; n < 8; n++)
         send_request(CMD_ALLOC, $urandom_range(0, 1), 4'($urandom_range(0, 1)), $urandom());
      drain();

      repeat (40) @(negedge clock);
      if (failures == 0 && pending == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

>>> filelist.f
design/pbpa_pkg.sv
design/pbpa_stack.sv
design/pbpa_blkdiv.sv
design/pbpa_csr.sv
design/paged_block_pool_allocator_core.sv
tb/pool_grant_checker.sv
tb/tb_paged_block_pool_allocator_core.sv
